// ===== hdl/life_grid_generation_engine_core_macros.svh =====
// Assertion macros used by the life grid engine sequencer (lge_ctrl).
`ifndef LIFE_GRID_GENERATION_ENGINE_CORE_MACROS_SVH
`define LIFE_GRID_GENERATION_ENGINE_CORE_MACROS_SVH
`ifndef SYNTH
`define LGE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define LGE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define LGE_ASSERT_IMP(lbl, ante, cons)
`define LGE_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== hdl/lge_pkg.sv =====
// Types and constants shared by the life grid engine modules.
`timescale 1ns / 1ps
package lge_pkg;

  localparam int FIELD_W = 6;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_STEP  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    RA_ITEM,
    RA_ZERO,
    RA_ONE,
    RA_AHEAD
  } rd_sel_t;

  typedef struct packed {
    logic    latch;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_item;
    logic    wr_sweep;
    logic    sweep_start;
    logic    sweep_adv;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       in_grid;
    logic       sweep_last;
    logic       ahead_ok;
    logic       out_free;
  } sts_t;

endpackage

// ===== hdl/lge_datapath.sv =====
// Grid memory, row sweep registers, next generation logic and result register.
`timescale 1ns / 1ps
module lge_datapath #(
  parameter int GRID_SIZE = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  lge_pkg::cmd_t               cmd,
  output lge_pkg::sts_t               sts,
  input  logic [1:0]                  command,
  input  logic [lge_pkg::FIELD_W-1:0] row,
  input  logic [lge_pkg::FIELD_W-1:0] column,
  input  logic                        cell_in,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        cell_out,
  output logic                        step_done
);

  localparam int RIDX_W = $clog2(GRID_SIZE);

  logic [1:0]                  op_q;
  logic [lge_pkg::FIELD_W-1:0] row_q;
  logic [lge_pkg::FIELD_W-1:0] col_q;
  logic                        cell_q;

  logic [GRID_SIZE-1:0] mem [GRID_SIZE];
  logic [GRID_SIZE-1:0] row_valid;
  logic [GRID_SIZE-1:0] rd_q;
  logic                 rd_v;
  logic [GRID_SIZE-1:0] rd_row;
  logic [RIDX_W-1:0]    ra;
  logic [RIDX_W:0]      ahead;

  logic [GRID_SIZE-1:0] above;
  logic [GRID_SIZE-1:0] cur;
  logic [RIDX_W-1:0]    sweep_row;

  logic [GRID_SIZE+1:0] pa, pc, pb;
  logic [3:0]           cnt [GRID_SIZE];
  logic [GRID_SIZE-1:0] nxt;
  logic [GRID_SIZE-1:0] below;
  logic [GRID_SIZE-1:0] merged;
  logic [RIDX_W-1:0]    wa;
  logic [GRID_SIZE-1:0] wd;

  // request latch
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_q   <= command;
      row_q  <= row;
      col_q  <= column;
      cell_q <= cell_in;
    end
  end

  assign ahead  = {1'b0, sweep_row} + (RIDX_W+1)'(2);
  assign rd_row = rd_v ? rd_q : '0;

  always_comb begin
    unique case (cmd.rd_sel)
      lge_pkg::RA_ITEM:  ra = row_q[RIDX_W-1:0];
      lge_pkg::RA_ZERO:  ra = '0;
      lge_pkg::RA_ONE:   ra = RIDX_W'(1);
      lge_pkg::RA_AHEAD: ra = ahead[RIDX_W-1:0];
      default:           ra = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_q <= mem[ra];
      rd_v <= row_valid[ra];
    end
  end

  always_comb begin
    merged = rd_row;
    merged[col_q[RIDX_W-1:0]] = cell_q;
  end

  assign wa = cmd.wr_sweep ? sweep_row : row_q[RIDX_W-1:0];
  assign wd = cmd.wr_sweep ? nxt : merged;

  always_ff @(posedge clk) begin
    if (cmd.wr_item || cmd.wr_sweep) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (cmd.wr_item || cmd.wr_sweep) begin
      row_valid[wa] <= 1'b1;
    end
  end

  // sweep: last row sees a dead row below
  assign below = sts.sweep_last ? '0 : rd_row;

  always_ff @(posedge clk) begin
    if (cmd.sweep_start) begin
      above     <= '0;
      cur       <= rd_row;
      sweep_row <= '0;
    end else if (cmd.sweep_adv) begin
      above     <= cur;
      cur       <= below;
      sweep_row <= sweep_row + RIDX_W'(1);
    end
  end

  assign pa = {1'b0, above, 1'b0};
  assign pc = {1'b0, cur, 1'b0};
  assign pb = {1'b0, below, 1'b0};

  always_comb begin
    for (int j = 0; j < GRID_SIZE; j++) begin
      cnt[j] = 4'(pa[j]) + 4'(pa[j+1]) + 4'(pa[j+2]) + 4'(pc[j]) + 4'(pc[j+2])
             + 4'(pb[j]) + 4'(pb[j+1]) + 4'(pb[j+2]);
      nxt[j] = (cnt[j] == 4'd3) || (cur[j] && cnt[j] == 4'd2);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      cell_out  <= (op_q == lge_pkg::OP_READ) && sts.in_grid && rd_row[col_q[RIDX_W-1:0]];
      step_done <= (op_q == lge_pkg::OP_STEP);
    end
  end

  assign sts.op         = op_q;
  assign sts.in_grid    = ({1'b0, row_q} < (lge_pkg::FIELD_W+1)'(GRID_SIZE)) &&
                          ({1'b0, col_q} < (lge_pkg::FIELD_W+1)'(GRID_SIZE));
  assign sts.sweep_last = (sweep_row == RIDX_W'(GRID_SIZE - 1));
  assign sts.ahead_ok   = (ahead < (RIDX_W+1)'(GRID_SIZE));
  assign sts.out_free   = !out_valid || !out_stall;

endmodule

// ===== hdl/lge_ctrl.sv =====
// Command sequencer for the life grid engine.
`timescale 1ns / 1ps
`include "life_grid_generation_engine_core_macros.svh"
module lge_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  lge_pkg::sts_t sts,
  output lge_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    IDLE,
    DECODE,
    WR_MOD,
    ST_LOAD,
    ST_RUN,
    RESP
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.rd_sel = lge_pkg::RA_ITEM;
    unique case (state)
      IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = DECODE;
        end
      end
      DECODE: begin
        unique case (sts.op)
          lge_pkg::OP_WRITE: begin
            cmd.rd_en  = sts.in_grid;
            state_next = sts.in_grid ? WR_MOD : RESP;
          end
          lge_pkg::OP_READ: begin
            cmd.rd_en  = sts.in_grid;
            state_next = RESP;
          end
          lge_pkg::OP_STEP: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = lge_pkg::RA_ZERO;
            state_next = ST_LOAD;
          end
          default: state_next = RESP;
        endcase
      end
      WR_MOD: begin
        cmd.wr_item = 1'b1;
        state_next  = RESP;
      end
      ST_LOAD: begin
        cmd.rd_en       = 1'b1;
        cmd.rd_sel      = lge_pkg::RA_ONE;
        cmd.sweep_start = 1'b1;
        state_next      = ST_RUN;
      end
      ST_RUN: begin
        cmd.wr_sweep  = 1'b1;
        cmd.sweep_adv = 1'b1;
        cmd.rd_en     = sts.ahead_ok;
        cmd.rd_sel    = lge_pkg::RA_AHEAD;
        if (sts.sweep_last) begin
          state_next = RESP;
        end
      end
      RESP: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  `LGE_ASSERT_NXT(a_accept_decode, in_valid && !in_stall, state == DECODE)
  `LGE_ASSERT_IMP(a_load_free, cmd.out_load, sts.out_free)
  `LGE_ASSERT_NXT(a_sweep_end, state == ST_RUN && sts.sweep_last, state == RESP)
  `LGE_ASSERT_IMP(a_no_write_idle, state == IDLE, !cmd.wr_item && !cmd.wr_sweep)

endmodule

// ===== hdl/life_grid_generation_engine_core.sv =====
// Life grid engine top level: sequencer plus grid datapath.
// One request at a time. A read or an unknown command goes through DECODE and RESP,
// a write through DECODE, WR_MOD (skipped off the grid) and RESP, a step through
// DECODE, ST_LOAD, ST_RUN and RESP; a new request is taken once RESP loads the result.
// Step time is set by the one-row-per-cycle sweep through the grid memory.
// Synchronous reset clears per-row valid flags, so the grid reads all dead,
// with no clearing pass; the result register is emptied.
`timescale 1ns / 1ps
module life_grid_generation_engine_core #(
  parameter int GRID_SIZE = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  command,
  input  logic [lge_pkg::FIELD_W-1:0] row,
  input  logic [lge_pkg::FIELD_W-1:0] column,
  input  logic                        cell_in,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        cell_out,
  output logic                        step_done
);

  lge_pkg::cmd_t cmd;
  lge_pkg::sts_t sts;

  lge_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  lge_datapath #(
    .GRID_SIZE (GRID_SIZE)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .command   (command),
    .row       (row),
    .column    (column),
    .cell_in   (cell_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cell_out  (cell_out),
    .step_done (step_done)
  );

endmodule

// ===== bench/life_grid_checker.sv =====
// Checker for the life grid engine: tracks the grid, predicts each result and compares.
`timescale 1ns / 1ps
module life_grid_checker #(
  parameter int GRID_SIZE = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [1:0]                  command,
  input  logic [lge_pkg::FIELD_W-1:0] row,
  input  logic [lge_pkg::FIELD_W-1:0] column,
  input  logic                        cell_in,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic                        cell_out,
  input  logic                        step_done,
  output int                          fail_count,
  output int                          results_owed
);

  typedef struct packed {
    logic live;
    logic done;
  } life_result_t;

  logic [63:0]  life_grid [64];
  life_result_t owed_results [$];
  life_result_t want;
  life_result_t got;
  int           mismatches = 0;

  assign fail_count = mismatches;

  task automatic report_mismatch(input string what, input logic seen, input logic wanted);
    $display("mismatch at %0t: %s (got %0b, want %0b)", $realtime, what, seen, wanted);
    mismatches++;
  endtask

  // Next generation from the old grid as a whole; cells off the grid are dead.
  function automatic void advance_life();
    logic [63:0] prev [64];
    int count;
    int rr;
    int cc;
    prev = life_grid;
    for (int r = 0; r < GRID_SIZE; r++) begin
      for (int c = 0; c < GRID_SIZE; c++) begin
        count = 0;
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            rr = r + dr;
            cc = c + dc;
            if ((dr != 0 || dc != 0) && rr >= 0 && rr < GRID_SIZE && cc >= 0 && cc < GRID_SIZE)
              count += prev[rr][cc];
          end
        end
        life_grid[r][c] = prev[r][c] ? (count == 2 || count == 3) : (count == 3);
      end
    end
  endfunction

  function automatic life_result_t predict_request(input logic [1:0] cmd,
                                                    input logic [lge_pkg::FIELD_W-1:0] r,
                                                    input logic [lge_pkg::FIELD_W-1:0] c,
                                                    input logic v);
    life_result_t res;
    logic in_grid;
    res = '0;
    in_grid = (int'(r) < GRID_SIZE) && (int'(c) < GRID_SIZE);
    case (cmd)
      lge_pkg::OP_WRITE: begin
        if (in_grid) life_grid[r][c] = v;
      end
      lge_pkg::OP_READ: begin
        if (in_grid) res.live = life_grid[r][c];
      end
      lge_pkg::OP_STEP: begin
        advance_life();
        res.done = 1'b1;
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < 64; r++) life_grid[r] = '0;
      owed_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got.live = cell_out;
        got.done = step_done;
        if (owed_results.size() == 0) begin
          report_mismatch("result with no request pending", cell_out, 1'b0);
        end else begin
          want = owed_results.pop_front();
          if (got.live !== want.live) report_mismatch("cell_out", got.live, want.live);
          if (got.done !== want.done) report_mismatch("step_done", got.done, want.done);
        end
      end
      if (in_valid && !in_stall)
        owed_results.push_back(predict_request(command, row, column, cell_in));
    end
    results_owed <= owed_results.size();
  end

endmodule

// ===== bench/testbench.sv =====
// Testbench top for the life grid engine: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps
module testbench;

  localparam int GRID_SIZE       = 64;
  localparam int RANDOM_REQUESTS = 1525;
  localparam int CYCLE_LIMIT     = 600000;
  localparam int HOLD_CYCLES     = 600;
  localparam logic [1:0] CMD_UNKNOWN = 2'd3;

  typedef enum {RX_FREE, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_t;

  logic                        clk;
  logic                        rst;
  logic                        in_valid;
  logic                        in_stall;
  logic [1:0]                  command;
  logic [lge_pkg::FIELD_W-1:0] row;
  logic [lge_pkg::FIELD_W-1:0] column;
  logic                        cell_in;
  logic                        out_valid;
  logic                        out_stall;
  logic                        cell_out;
  logic                        step_done;
  int                          fail_count;
  int                          results_owed;
  int                          cycles;

  life_grid_generation_engine_core #(.GRID_SIZE(GRID_SIZE)) u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .row(row), .column(column), .cell_in(cell_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .cell_out(cell_out), .step_done(step_done)
  );

  life_grid_checker #(.GRID_SIZE(GRID_SIZE)) u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .row(row), .column(column), .cell_in(cell_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .cell_out(cell_out), .step_done(step_done),
    .fail_count(fail_count), .results_owed(results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles", cycles);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Receiver stall pattern, with long hold-offs so the engine backs up.
  initial begin : receiver
    int       seg_left;
    int       rx_cycles;
    int       hold_left;
    rx_mode_t mode;
    out_stall = 1'b0;
    seg_left  = 0;
    rx_cycles = 0;
    hold_left = 0;
    mode      = RX_FREE;
    forever begin
      @(posedge clk);
      rx_cycles++;
      if (rx_cycles == 2500 || rx_cycles == 15000) hold_left = HOLD_CYCLES;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (seg_left == 0) begin
          mode     = rx_mode_t'($urandom_range(0, 3));
          seg_left = $urandom_range(10, 200);
        end
        seg_left--;
        case (mode)
          RX_FREE:  out_stall <= 1'b0;
          RX_LIGHT: out_stall <= ($urandom_range(0, 4) == 0);
          RX_HEAVY: out_stall <= ($urandom_range(0, 2) != 0);
          default:  out_stall <= ~out_stall;
        endcase
      end
    end
  end

  task automatic send_request(input logic [1:0] cmd, input logic [lge_pkg::FIELD_W-1:0] r,
                              input logic [lge_pkg::FIELD_W-1:0] c, input logic v);
    command  <= cmd;
    row      <= r;
    column   <= c;
    cell_in  <= v;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic logic [lge_pkg::FIELD_W-1:0] near_cell(input int center);
    int v;
    v = center + int'($urandom_range(0, 6)) - 3;
    if (v < 0) v = 0;
    if (v > GRID_SIZE - 1) v = GRID_SIZE - 1;
    return (lge_pkg::FIELD_W)'(v);
  endfunction

  initial begin : stimulus
    int                          burst_left;
    int                          gap;
    int                          roll;
    int                          center_r;
    int                          center_c;
    logic [lge_pkg::FIELD_W-1:0] r;
    logic [lge_pkg::FIELD_W-1:0] c;
    rst      = 1'b1;
    in_valid = 1'b0;
    command  = lge_pkg::OP_WRITE;
    row      = '0;
    column   = '0;
    cell_in  = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // corners: live, read back, then all die on a step
    send_request(lge_pkg::OP_WRITE, 6'd0, 6'd0, 1'b1);
    send_request(lge_pkg::OP_WRITE, 6'd0, 6'd63, 1'b1);
    send_request(lge_pkg::OP_WRITE, 6'd63, 6'd0, 1'b1);
    send_request(lge_pkg::OP_WRITE, 6'd63, 6'd63, 1'b1);
    send_request(lge_pkg::OP_READ, 6'd0, 6'd0, 1'b0);
    send_request(lge_pkg::OP_READ, 6'd63, 6'd63, 1'b1);
    send_request(lge_pkg::OP_READ, 6'd0, 6'd63, 1'b0);
    send_request(lge_pkg::OP_READ, 6'd63, 6'd0, 1'b0);
    send_request(lge_pkg::OP_STEP, 6'd63, 6'd63, 1'b1);
    send_request(lge_pkg::OP_READ, 6'd0, 6'd0, 1'b0);
    send_request(lge_pkg::OP_READ, 6'd63, 6'd63, 1'b0);
    // vertical blinker on the right edge column
    send_request(lge_pkg::OP_WRITE, 6'd20, 6'd63, 1'b1);
    send_request(lge_pkg::OP_WRITE, 6'd21, 6'd63, 1'b1);
    send_request(lge_pkg::OP_WRITE, 6'd22, 6'd63, 1'b1);
    send_request(lge_pkg::OP_STEP, 6'd0, 6'd0, 1'b0);
    send_request(lge_pkg::OP_READ, 6'd21, 6'd62, 1'b0);
    send_request(lge_pkg::OP_READ, 6'd21, 6'd63, 1'b0);
    send_request(lge_pkg::OP_READ, 6'd20, 6'd63, 1'b0);
    // unknown command must not touch the grid
    send_request(CMD_UNKNOWN, 6'd21, 6'd63, 1'b0);
    send_request(CMD_UNKNOWN, 6'd63, 6'd63, 1'b1);
    send_request(lge_pkg::OP_READ, 6'd63, 6'd63, 1'b1);
    send_request(lge_pkg::OP_WRITE, 6'd21, 6'd63, 1'b0);
    send_request(lge_pkg::OP_READ, 6'd21, 6'd63, 1'b1);
    send_request(lge_pkg::OP_WRITE, 6'd5, 6'd5, 1'b0);
    send_request(lge_pkg::OP_STEP, 6'd0, 6'd0, 1'b0);

    burst_left = $urandom_range(1, 24);
    center_r   = 0;
    center_c   = 0;
    for (int k = 0; k < RANDOM_REQUESTS; k++) begin
      if (k % 120 == 0) begin
        if ($urandom_range(0, 2) == 0) begin
          center_r = $urandom_range(0, 1) ? 0 : GRID_SIZE - 1;
          center_c = $urandom_range(0, 1) ? 0 : GRID_SIZE - 1;
        end else begin
          center_r = $urandom_range(0, GRID_SIZE - 1);
          center_c = $urandom_range(0, GRID_SIZE - 1);
        end
      end
      if ($urandom_range(0, 9) < 6) begin
        r = near_cell(center_r);
        c = near_cell(center_c);
      end else begin
        r = (lge_pkg::FIELD_W)'($urandom);
        c = (lge_pkg::FIELD_W)'($urandom);
      end
      roll = $urandom_range(0, 99);
      if (roll < 45)      send_request(lge_pkg::OP_WRITE, r, c, $urandom_range(0, 3) != 0);
      else if (roll < 80) send_request(lge_pkg::OP_READ, r, c, 1'($urandom));
      else if (roll < 93) send_request(lge_pkg::OP_STEP, r, c, 1'($urandom));
      else                send_request(CMD_UNKNOWN, r, c, 1'($urandom));
      burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap        = $urandom_range(0, 8);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (GRID_SIZE + 16) @(posedge clk);
    if (fail_count == 0 && results_owed == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
